// ===== hw/rtl/hpc_pkg.sv =====
// ----------------------------------------------------------------------------
// hpc_pkg: shared types and constants for the heater/pump cycle controller
// Holds the mode codes, the register indexes, the cycle timings and the
// controller state record.
// ----------------------------------------------------------------------------
`default_nettype none

package hpc_pkg;

	// operating modes
	localparam logic [1:0] MODE_STOP = 2'd0;
	localparam logic [1:0] MODE_FERM = 2'd1;
	localparam logic [1:0] MODE_FILT = 2'd2;
	localparam logic [1:0] MODE_TEMP = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_MODE        = 2'd0;
	localparam logic [1:0] REG_TARGET_TEMP = 2'd1;
	localparam logic [1:0] REG_PUMP_ON_MS  = 2'd2;
	localparam logic [1:0] REG_PUMP_OFF_MS = 2'd3;

	// register reset values
	localparam logic [1:0]         MODE_RESET        = MODE_STOP;
	localparam logic signed [11:0] TARGET_TEMP_RESET = 12'sd1040;
	localparam logic [31:0]        PUMP_ON_RESET     = 32'd30000;
	localparam logic [31:0]        PUMP_OFF_RESET    = 32'd30000;

	// timings in ms
	localparam logic [31:0] CYCLE_MS     = 32'd180000;
	localparam logic [31:0] FERM_HEAT_MS = 32'd60000;
	localparam logic [31:0] FERM_PUMP_MS = 32'd90000;
	localparam logic [31:0] FILT_MS      = 32'd120000;
	localparam logic [31:0] CHECK_MS     = 32'd1000;

	typedef struct packed {
		logic [31:0] cycle_start;
		logic        heat_flag;
		logic        pump_flag;
		logic [31:0] last_check;
		logic [31:0] phase_start;
		logic        pump_running;
		logic        pump_forced;
		logic        heater_level;
		logic        pump_level;
	} hpc_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/heater_pump_cycle_controller.sv =====
// ----------------------------------------------------------------------------
// heater_pump_cycle_controller: heater and pump relay sequencer
// Stream of timestamp/temperature beats in, one relay-level beat out per
// input beat; mode and timing set through a simple write port.
// ----------------------------------------------------------------------------
// Each input beat carries a free-running millisecond time and a temperature
// in 1/16 degree C; each one yields exactly one output beat with the heater
// and pump relay levels after that sample. Mode 0 stops both relays, modes 1
// and 2 run the fixed 180 s fermentation and filtration cycles, mode 3 runs
// once-a-second temperature control with cyclic pumping. Throughput is one
// beat per clock while the output is not stalled; the input register loads
// on the input accept edge, and the relay-state update loads the output
// register once the output slot is free or being drained.
// The whole update is one pass of subtract/compare logic between those two
// registers. Registers may be written only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module heater_pump_cycle_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_data,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // [31:0] now_ms, [43:32] temperature, [47:44] zero
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [0] heater_on, [1] pump_on, [7:2] zero
);

	// configuration registers
	logic [1:0]         mode_q;
	logic signed [11:0] target_temp_q;
	logic [31:0]        pump_on_ms_q;
	logic [31:0]        pump_off_ms_q;

	// input register
	logic               valid_s1;
	logic [31:0]        now_ms_s1;
	logic signed [11:0] temperature_s1;

	// output register
	logic               valid_s2;
	logic               heater_s2;
	logic               pump_s2;

	hpc_pkg::hpc_state_t state_q;
	hpc_pkg::hpc_state_t state_nxt;

	logic advance;

	// s1 moves on whenever the output slot is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= hpc_pkg::MODE_RESET;
			target_temp_q <= hpc_pkg::TARGET_TEMP_RESET;
			pump_on_ms_q  <= hpc_pkg::PUMP_ON_RESET;
			pump_off_ms_q <= hpc_pkg::PUMP_OFF_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				hpc_pkg::REG_MODE:        mode_q        <= cfg_data[1:0];
				hpc_pkg::REG_TARGET_TEMP: target_temp_q <= cfg_data[11:0];
				hpc_pkg::REG_PUMP_ON_MS:  pump_on_ms_q  <= cfg_data;
				hpc_pkg::REG_PUMP_OFF_MS: pump_off_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_ms_s1      <= s_tdata[31:0];
			temperature_s1 <= s_tdata[43:32];
		end
	end

	hpc_step u_step (
		.cur         (state_q),
		.mode        (mode_q),
		.target_temp (target_temp_q),
		.pump_on_ms  (pump_on_ms_q),
		.pump_off_ms (pump_off_ms_q),
		.now_ms      (now_ms_s1),
		.temperature (temperature_s1),
		.nxt         (state_nxt)
	);

	// controller state commits as each beat moves into the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heater_s2 <= state_nxt.heater_level;
			pump_s2   <= state_nxt.pump_level;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, pump_s2, heater_s2};

endmodule

`default_nettype wire

// ===== hw/rtl/hpc_step.sv =====
// ----------------------------------------------------------------------------
// hpc_step: next-state logic for one sample
// Given the current controller state, the registers and one timestamp and
// temperature beat, works out the state after that beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hpc_step (
	input  wire hpc_pkg::hpc_state_t cur,
	input  wire logic [1:0]          mode,
	input  wire logic signed [11:0]  target_temp,
	input  wire logic [31:0]         pump_on_ms,
	input  wire logic [31:0]         pump_off_ms,
	input  wire logic [31:0]         now_ms,
	input  wire logic signed [11:0]  temperature,
	output hpc_pkg::hpc_state_t      nxt
);

	logic [31:0] cycle_elapsed;
	logic [31:0] check_elapsed;
	logic [31:0] phase_elapsed;
	logic [31:0] heat_ms;
	logic [31:0] pump_ms;
	logic        below;

	// all differences wrap at 32 bits
	assign cycle_elapsed = now_ms - cur.cycle_start;
	assign check_elapsed = now_ms - cur.last_check;
	assign phase_elapsed = now_ms - cur.phase_start;
	assign heat_ms = (mode == hpc_pkg::MODE_FERM) ? hpc_pkg::FERM_HEAT_MS : hpc_pkg::FILT_MS;
	assign pump_ms = (mode == hpc_pkg::MODE_FERM) ? hpc_pkg::FERM_PUMP_MS : hpc_pkg::FILT_MS;
	assign below   = temperature < target_temp;

	always_comb begin
		logic skip_cyclic;
		skip_cyclic = 1'b0;
		nxt = cur;
		case (mode)
			hpc_pkg::MODE_STOP: begin
				nxt.cycle_start  = '0;
				nxt.heater_level = 1'b0;
				nxt.pump_level   = 1'b0;
			end
			hpc_pkg::MODE_FERM,
			hpc_pkg::MODE_FILT: begin
				if (cycle_elapsed >= hpc_pkg::CYCLE_MS) begin
					nxt.heater_level = 1'b1;
					nxt.pump_level   = 1'b1;
					nxt.heat_flag    = 1'b1;
					nxt.pump_flag    = 1'b1;
					nxt.cycle_start  = now_ms;
				end else begin
					if (cur.heat_flag && cycle_elapsed >= heat_ms) begin
						nxt.heater_level = 1'b0;
						nxt.heat_flag    = 1'b0;
					end
					if (cur.pump_flag && cycle_elapsed >= pump_ms) begin
						nxt.pump_level = 1'b0;
						nxt.pump_flag  = 1'b0;
					end
				end
			end
			default: begin
				// temperature control, checked once a second
				if (check_elapsed >= hpc_pkg::CHECK_MS) begin
					nxt.last_check = now_ms;
					if (below) begin
						if (!cur.heat_flag) begin
							nxt.heater_level = 1'b1;
							nxt.heat_flag    = 1'b1;
						end
						nxt.pump_forced = 1'b0;
					end else begin
						if (cur.heat_flag) begin
							nxt.heater_level = 1'b0;
							nxt.heat_flag    = 1'b0;
						end
						if (!cur.pump_forced) begin
							nxt.pump_level   = 1'b1;
							nxt.pump_running = 1'b1;
							nxt.pump_forced  = 1'b1;
						end
						skip_cyclic = 1'b1;
					end
				end
				// cyclic pumping uses the forced flag as updated above
				if (!skip_cyclic && !nxt.pump_forced) begin
					if (cur.pump_running) begin
						if (phase_elapsed >= pump_on_ms) begin
							nxt.pump_level   = 1'b0;
							nxt.pump_running = 1'b0;
							nxt.phase_start  = now_ms;
						end
					end else if (phase_elapsed >= pump_off_ms) begin
						nxt.pump_level   = 1'b1;
						nxt.pump_running = 1'b1;
						nxt.phase_start  = now_ms;
					end
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sim/tb_heater_pump_cycle_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heater_pump_cycle_controller: self-checking bench for the relay sequencer
// Drives timestamp/temperature beats through every mode. A predictor of the
// relay state machine builds one expected relay beat per accepted input beat.
// The output stream is checked against those expectations in order, with
// random idle gaps and backpressure on both sides.
// ----------------------------------------------------------------------------

module tb_heater_pump_cycle_controller;
	import hpc_pkg::*;

	// expected relay levels of one output beat
	typedef struct packed {
		logic heater;
		logic pump;
	} relay_t;

	// Relay state predictor plus the queue of relay beats still owed by the DUT.
	class relay_scoreboard;
		// register copy
		logic [1:0]         mode;
		logic signed [11:0] target;
		logic [31:0]        on_ms;
		logic [31:0]        off_ms;
		// controller state copy
		logic [31:0]        cycle_start;
		logic [31:0]        last_check;
		logic [31:0]        phase_start;
		bit                 heat_flag;
		bit                 pump_flag;
		bit                 pump_running;
		bit                 pump_forced;
		bit                 heater;
		bit                 pump;
		relay_t             relay_q[$];
		int                 errors;

		function new();
			mode         = MODE_RESET;
			target       = TARGET_TEMP_RESET;
			on_ms        = PUMP_ON_RESET;
			off_ms       = PUMP_OFF_RESET;
			cycle_start  = '0;
			last_check   = '0;
			phase_start  = '0;
			heat_flag    = 0;
			pump_flag    = 0;
			pump_running = 0;
			pump_forced  = 0;
			heater       = 0;
			pump         = 0;
			errors       = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_MODE:        mode   = val[1:0];
				REG_TARGET_TEMP: target = val[11:0];
				REG_PUMP_ON_MS:  on_ms  = val;
				REG_PUMP_OFF_MS: off_ms = val;
				default: ;
			endcase
		endfunction

		// advance the relay state by one sample and queue the resulting levels
		function void note_input(logic [31:0] now, logic signed [11:0] temp);
			logic [31:0] elapsed;
			logic [31:0] heat_limit;
			logic [31:0] pump_limit;
			bit          went_hot;
			relay_t      r;
			went_hot = 0;
			case (mode)
				MODE_STOP: begin
					cycle_start = '0;
					heater      = 0;
					pump        = 0;
				end
				MODE_FERM, MODE_FILT: begin
					heat_limit = (mode == MODE_FERM) ? FERM_HEAT_MS : FILT_MS;
					pump_limit = (mode == MODE_FERM) ? FERM_PUMP_MS : FILT_MS;
					elapsed    = now - cycle_start;
					if (elapsed >= CYCLE_MS) begin
						// new cycle: everything on, nothing else this step
						heater      = 1;
						pump        = 1;
						heat_flag   = 1;
						pump_flag   = 1;
						cycle_start = now;
					end else begin
						if (heat_flag && elapsed >= heat_limit) begin
							heater    = 0;
							heat_flag = 0;
						end
						if (pump_flag && elapsed >= pump_limit) begin
							pump      = 0;
							pump_flag = 0;
						end
					end
				end
				default: begin
					elapsed = now - last_check;
					if (elapsed >= CHECK_MS) begin
						last_check = now;
						if (temp < target) begin
							if (!heat_flag) begin
								heater    = 1;
								heat_flag = 1;
							end
							pump_forced = 0;
						end else begin
							if (heat_flag) begin
								heater    = 0;
								heat_flag = 0;
							end
							if (!pump_forced) begin
								pump         = 1;
								pump_running = 1;
								pump_forced  = 1;
							end
							went_hot = 1;
						end
					end
					// cyclic pumping, skipped on a hot check
					if (!went_hot && !pump_forced) begin
						elapsed = now - phase_start;
						if (pump_running) begin
							if (elapsed >= on_ms) begin
								pump         = 0;
								pump_running = 0;
								phase_start  = now;
							end
						end else if (elapsed >= off_ms) begin
							pump         = 1;
							pump_running = 1;
							phase_start  = now;
						end
					end
				end
			endcase
			r.heater = heater;
			r.pump   = pump;
			relay_q.push_back(r);
		endfunction

		function void check_result(logic [7:0] beat);
			relay_t want;
			if (relay_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected relay beat, actual heater %0b pump %0b",
					$time, beat[0], beat[1]);
				return;
			end
			want = relay_q.pop_front();
			if (beat[0] !== want.heater) begin
				errors++;
				$display("%0t: heater_on mismatch, expected %0b actual %0b",
					$time, want.heater, beat[0]);
			end
			if (beat[1] !== want.pump) begin
				errors++;
				$display("%0t: pump_on mismatch, expected %0b actual %0b",
					$time, want.pump, beat[1]);
			end
		endfunction

		function int pending();
			return relay_q.size();
		endfunction
	endclass

	localparam int NUM_PHASES      = 12;
	localparam int BEATS_PER_PHASE = 60;
	localparam int RX_HOLD_CYCLES  = 200;   // long output stall to back up the pipe

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;    // [31:0] now_ms, [43:32] temperature, [47:44] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // [0] heater_on, [1] pump_on, [7:2] zero

	relay_scoreboard sb;
	bit              no_idle;      // both sides run gap-free while set
	bit              rx_hold_req;  // receiver takes one long stall when set

	heater_pump_cycle_controller u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case the DUT hangs
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Offer one beat after a random gap and wait for the handshake. valid stays
	// high across back-to-back beats so it is never dropped and re-raised.
	task automatic send_beat(input logic [31:0] now, input logic signed [11:0] temp);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, temp, now};
		do @(posedge clk); while (!s_tready);
		sb.note_input(now, temp);
	endtask

	// Drop valid, wait for every owed beat, then let the two-stage pipe drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write; the trailing edge keeps cfg_we from being lowered
	// and raised again in the same step on back-to-back writes
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// time advance: mostly short steps around the 1 s check and pump phases,
	// some long ones to cross the 180 s cycle, a few arbitrary jumps
	function automatic logic [31:0] next_step(input logic [1:0] mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == MODE_TEMP) begin
			if (r < 75)      return $urandom_range(0, 2500);
			else if (r < 95) return $urandom_range(0, 40000);
			else             return $urandom();
		end
		if (r < 60)      return $urandom_range(0, 20000);
		else if (r < 90) return $urandom_range(0, 70000);
		else if (r < 97) return $urandom_range(0, 200000);
		return $urandom();
	endfunction

	// temperatures cluster around the target so checks flip often
	function automatic logic signed [11:0] pick_temp(input logic signed [11:0] target);
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			v = target;
			v = v + $urandom_range(0, 64) - 32;
		end else if (r < 9) begin
			v = $urandom_range(0, 2880) - 880;
		end else begin
			v = $urandom_range(0, 4095) - 2048;   // full 12-bit field
		end
		return v[11:0];
	endfunction

	function automatic logic [31:0] pick_pump_ms();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'd30000;
			3:       return $urandom();
			default: return $urandom_range(1, 4000);
		endcase
	endfunction

	// Output side: random stalls, one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				int stall;
				stall = no_idle ? 0 : $urandom_range(0, 12);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	// Main sequence: reset, directed cases, random phases, drain, verdict.
	initial begin
		logic [31:0]        t_ms;
		logic [1:0]         mode;
		logic signed [11:0] target;
		logic [31:0]        on_ms;
		logic [31:0]        off_ms;
		sb          = new();
		no_idle     = 0;
		rx_hold_req = 0;
		arst_n      = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		cfg_we   <= 1'b0;
		cfg_addr <= '0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stop mode out of reset, extremes of time and temperature
		send_beat(32'd0, -12'sd880);
		send_beat(32'hFFFF_FFFF, 12'sd2000);

		// fermentation: edges of the 180 s start, 60 s heater and 90 s pump limits
		settle();
		write_reg(REG_MODE, {30'd0, MODE_FERM});
		send_beat(32'd179999, 12'sd0);
		send_beat(32'd180000, 12'sd0);
		send_beat(32'd239999, 12'sd0);
		send_beat(32'd240000, 12'sd0);
		send_beat(32'd270000, 12'sd0);
		send_beat(32'd360000, 12'sd0);

		// stop clears the cycle start but leaves the flags set
		settle();
		write_reg(REG_MODE, {30'd0, MODE_STOP});
		send_beat(32'hFFFF_0000, 12'sd100);

		// filtration across the 32-bit time wrap, 120 s limit exactly
		settle();
		write_reg(REG_MODE, {30'd0, MODE_FILT});
		send_beat(32'hFFFF_0000, 12'sd100);
		send_beat(32'h0000_D000, 12'sd100);
		send_beat(32'h0000_D4C0, 12'sd100);
		send_beat(32'd234464, 12'sd100);    // restart, flags set again

		// stop with heat flag left set
		settle();
		write_reg(REG_MODE, {30'd0, MODE_STOP});
		send_beat(32'd240000, 12'sd0);

		// temperature control on reset target: stale heat flag keeps the heater
		// off, hot sample forces the pump, cold sample releases it
		settle();
		write_reg(REG_MODE, {30'd0, MODE_TEMP});
		send_beat(32'd241000, 12'sd500);
		send_beat(32'd242000, 12'sd2047);
		send_beat(32'd243000, -12'sd2048);

		// zero on and off times: pump toggles every beat between checks
		settle();
		write_reg(REG_PUMP_ON_MS, 32'd0);
		write_reg(REG_PUMP_OFF_MS, 32'd0);
		send_beat(32'd243001, 12'sd0);
		send_beat(32'd243002, 12'sd0);

		// target extremes: equal counts as hot, one below as cold
		settle();
		write_reg(REG_TARGET_TEMP, -32'sd880);
		send_beat(32'd244002, -12'sd880);
		send_beat(32'd245002, -12'sd881);
		settle();
		write_reg(REG_TARGET_TEMP, 32'd2000);
		send_beat(32'd246002, 12'sd2000);
		send_beat(32'd247002, 12'sd1999);

		// random phases, each with its own register setting
		t_ms = 32'd247002;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			no_idle = (ph % 4 == 1);
			mode    = (ph < 8) ? ph[1:0] : 2'($urandom_range(0, 3));
			if (ph == 2)
				target = -12'sd880;
			else if (ph == 3)
				target = 12'sd2000;
			else
				target = 12'($urandom_range(0, 2880) - 880);
			if (ph == 7) begin
				on_ms  = 32'd0;
				off_ms = 32'hFFFF_FFFF;
			end else if (ph == 11) begin
				on_ms  = 32'hFFFF_FFFF;
				off_ms = 32'd0;
			end else begin
				on_ms  = pick_pump_ms();
				off_ms = pick_pump_ms();
			end
			write_reg(REG_TARGET_TEMP, {{20{target[11]}}, target});
			write_reg(REG_PUMP_ON_MS, on_ms);
			write_reg(REG_PUMP_OFF_MS, off_ms);
			write_reg(REG_MODE, {30'd0, mode});
			// back the pipe up: output held while input keeps offering
			if (ph == 5)
				rx_hold_req = 1;
			for (int i = 0; i < BEATS_PER_PHASE; i++) begin
				// input pause until every owed beat is out, then resume
				if (ph == 6 && i == BEATS_PER_PHASE / 2) begin
					s_tvalid <= 1'b0;
					while (sb.pending() != 0) @(posedge clk);
				end
				t_ms = t_ms + next_step(mode);
				send_beat(t_ms, pick_temp(target));
			end
		end

		// drain and verdict
		s_tvalid <= 1'b0;
		no_idle = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d relay beats never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/hpc_pkg.sv
hw/rtl/hpc_step.sv
hw/rtl/heater_pump_cycle_controller.sv
sim/tb_heater_pump_cycle_controller.sv
